// File: rtl/vru_pkg.sv
// shared types and constants for the vram rectangle upload block
// no dependencies; imported by every module of the block
package vru_pkg;

    localparam int LINE_PIXELS_DEFAULT = 1024;

    localparam int ADDR_W  = 19;
    localparam int PIXEL_W = 16;
    localparam int COL_W   = 10;
    localparam int LINE_W  = 9;
    localparam int WIDTH_W = 11;
    localparam int HEIGHT_W = 10;
    localparam int POS_W   = 11;
    localparam int WORD_W  = 32;

    localparam logic [WIDTH_W-1:0]  MAX_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 10'd512;

    // result buffer geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                 op;
        logic [COL_W-1:0]    x_start;
        logic [LINE_W-1:0]   y_start;
        logic [WIDTH_W-1:0]  rect_width;
        logic [HEIGHT_W-1:0] rect_height;
        logic [WORD_W-1:0]   data_word;
    } in_item_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]  vram_address;
        logic [PIXEL_W-1:0] pixel;
        logic               last_of_word;
        logic               transfer_done;
    } result_t;

    // up to two results handed from the walker to the result buffer
    typedef struct packed
    {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed
    {
        logic             active;
        logic [COL_W-1:0] col_start;
        logic [POS_W-1:0] col_end;
        logic [POS_W-1:0] line_end;
        logic [POS_W-1:0] col_pos;
        logic [POS_W-1:0] line_pos;
    } walk_state_t;

endpackage

// File: rtl/vram_rectangle_upload.sv
// top level of the vram rectangle upload block: input register, walker
// and result buffer; depends on vru_pkg, vru_walker and vru_result_fifo
//
// A start item (tuser 0) opens a rectangle; each data word (tuser 1) then
// yields one vram halfword write per pixel, low pixel first, until the
// rectangle is filled. Items enter an input register one per cycle while
// the buffer has room for their writes and are resolved combinationally
// by the walker; a start item or a word outside a transfer leaves that
// register with no write. Writes leave through a four-entry result buffer
// at one per cycle while m_tready is high; a new word may enter while
// earlier writes still wait in the buffer. An accepted word passes the
// input register and the result buffer before its first write appears.
// The address is line*LINE_PIXELS+column modulo 2^19; tlast marks the
// last write of a word and tuser the write that closed the rectangle.
module vram_rectangle_upload #(
    parameter int LINE_PIXELS = vru_pkg::LINE_PIXELS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_start[9:0], y_start[18:10], rect_width[29:19], rect_height[39:30],
    // data_word[71:40]
    input  logic [71:0] s_tdata,
    // op[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // vram_address[18:0], pixel[34:19], zero[39:35]
    output logic [39:0] m_tdata,
    // transfer_done[0]
    output logic        m_tuser,
    output logic        m_tlast
);
    import vru_pkg::*;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    in_item_t              in_item_reg;
    in_item_t              in_item_next;
    logic                  s_fire;
    logic                  fire;
    push_t                 push;
    logic [FIFO_CNT_W-1:0] fifo_count;
    result_t               head;

    assign s_fire = s_tvalid && s_tready;

    // an item leaves the input register once its writes fit in the buffer
    assign fire = in_valid_reg
        && ((FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(push.n)
            <= (FIFO_CNT_W + 1)'(FIFO_DEPTH));

    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        in_item_next.op          = op_t'(s_tuser);
        in_item_next.x_start     = s_tdata[9:0];
        in_item_next.y_start     = s_tdata[18:10];
        in_item_next.rect_width  = s_tdata[29:19];
        in_item_next.rect_height = s_tdata[39:30];
        in_item_next.data_word   = s_tdata[71:40];
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= in_item_next;
        end
    end

    vru_walker #(
        .LINE_PIXELS (LINE_PIXELS)
    ) u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .push  (push)
    );

    vru_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (fire),
        .push       (push),
        .count      (fifo_count),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = {5'b0, head.pixel, head.vram_address};
    assign m_tuser = head.transfer_done;
    assign m_tlast = head.last_of_word;

    // the buffer never holds more than its depth
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result buffer overflow");

    // a start item never produces a write
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_item_reg.op == OP_START |-> push.n == 2'd0)
        else $error("start item produced a write");

    // the write that closes a rectangle is always the last of its word
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("transfer_done without last_of_word");

    // a stalled input item is not consumed while the buffer lacks room
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_item_reg))
        else $error("input item lost while stalled");

endmodule

// File: rtl/vru_walker.sv
// rectangle walker: holds the transfer position and turns one item into
// up to two vram writes; depends on vru_pkg
module vru_walker #(
    parameter int LINE_PIXELS = vru_pkg::LINE_PIXELS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  vru_pkg::in_item_t item,
    output vru_pkg::push_t    push
);
    import vru_pkg::*;

    localparam logic [ADDR_W-1:0] LINE_STRIDE = ADDR_W'(LINE_PIXELS);

    walk_state_t state_reg;
    walk_state_t state_next;
    walk_state_t walk_state;
    walk_state_t start_state;
    result_t     res [2];
    logic [1:0]  n_res;

    // two dependent pixel steps on the current position
    always_comb
    begin : walk
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] line;
        logic [ADDR_W-1:0] line_base;
        walk_state = state_reg;
        col        = '0;
        line       = '0;
        line_base  = '0;
        n_res = 2'd0;
        res[0] = '0;
        res[1] = '0;
        for (int k = 0; k < 2; k++)
        begin
            if (item.op == OP_DATA && walk_state.active)
            begin
                line_base = ADDR_W'(walk_state.line_pos) * LINE_STRIDE;
                res[k].vram_address = line_base + ADDR_W'(walk_state.col_pos);
                res[k].pixel = item.data_word[k*PIXEL_W +: PIXEL_W];
                col  = walk_state.col_pos + 1'b1;
                line = walk_state.line_pos;
                if (col >= walk_state.col_end)
                begin
                    col  = POS_W'(walk_state.col_start);
                    line = line + 1'b1;
                end
                walk_state.col_pos  = col;
                walk_state.line_pos = line;
                if (line >= walk_state.line_end)
                begin
                    walk_state.active = 1'b0;
                    res[k].transfer_done = 1'b1;
                end
                n_res = n_res + 1'b1;
            end
        end
        if (n_res == 2'd2)
        begin
            res[1].last_of_word = 1'b1;
        end
        else if (n_res == 2'd1)
        begin
            res[0].last_of_word = 1'b1;
        end
    end

    always_comb
    begin : start
        logic [WIDTH_W-1:0]  w_sat;
        logic [HEIGHT_W-1:0] h_sat;
        w_sat = (item.rect_width > MAX_WIDTH) ? MAX_WIDTH : item.rect_width;
        h_sat = (item.rect_height > MAX_HEIGHT) ? MAX_HEIGHT : item.rect_height;
        start_state.col_start = item.x_start;
        start_state.col_pos   = POS_W'(item.x_start);
        start_state.line_pos  = POS_W'(item.y_start);
        start_state.col_end   = POS_W'(item.x_start) + POS_W'(w_sat);
        start_state.line_end  = POS_W'(item.y_start) + POS_W'(h_sat);
        start_state.active    = (w_sat != '0) && (h_sat != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        if (fire)
        begin
            state_next = (item.op == OP_START) ? start_state : walk_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign push.n  = n_res;
    assign push.r0 = res[0];
    assign push.r1 = res[1];

endmodule

// File: rtl/vru_result_fifo.sv
// four-entry result buffer, two writes and one read per cycle
// depends on vru_pkg
module vru_result_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push_en,
    input  vru_pkg::push_t                      push,
    output logic [vru_pkg::FIFO_CNT_W-1:0]      count,
    output logic                                head_valid,
    input  logic                                head_ready,
    output vru_pkg::result_t                    head
);
    import vru_pkg::*;

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [1:0]            n_push;
    logic                  pop;

    assign n_push = push_en ? push.n : 2'd0;
    assign pop    = head_valid && head_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (n_push == 2'd2)
        begin
            mem[FIFO_PTR_W'(wr_ptr_reg + 1'b1)] <= push.r1;
        end
    end

    assign count      = count_reg;
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

endmodule
